@@ sv/bracket_balance_checker_defines.svh @@
// Assertion macros for the bracket balance checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define BBC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/bbc_pkg.sv @@
// Shared types, codes and constants of the bracket balance checker.
// No dependencies.
package bbc_pkg;

   localparam int unsigned DEF_STACK_DEPTH = 64;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned STATUS_W        = 3;
   localparam int unsigned OPEN_W          = 7;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam logic [BYTE_W-1:0] CH_OPEN_ROUND   = 8'h28;
   localparam logic [BYTE_W-1:0] CH_CLOSE_ROUND  = 8'h29;
   localparam logic [BYTE_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
   localparam logic [BYTE_W-1:0] CH_OPEN_CURLY   = 8'h7B;
   localparam logic [BYTE_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LEFT     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd4;

   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_SKIP = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2,
      OP_END  = 2'd3
   } op_type;

   typedef struct packed {
      op_type   op;
      kind_type kind;
   } cmd_type;

   function automatic cmd_type classify(input logic [BYTE_W-1:0] text_byte,
                                        input logic end_of_text);
      cmd_type cmd;
      cmd.op   = OP_SKIP;
      cmd.kind = KIND_ROUND;
      if (end_of_text) begin
         cmd.op = OP_END;
      end else begin
         unique case (text_byte)
            CH_OPEN_ROUND:   begin cmd.op = OP_PUSH; cmd.kind = KIND_ROUND;  end
            CH_OPEN_SQUARE:  begin cmd.op = OP_PUSH; cmd.kind = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin cmd.op = OP_PUSH; cmd.kind = KIND_CURLY;  end
            CH_CLOSE_ROUND:  begin cmd.op = OP_POP;  cmd.kind = KIND_ROUND;  end
            CH_CLOSE_SQUARE: begin cmd.op = OP_POP;  cmd.kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin cmd.op = OP_POP;  cmd.kind = KIND_CURLY;  end
            default:         cmd.op = OP_SKIP;
         endcase
      end
      return cmd;
   endfunction

endpackage

@@ sv/bbc_channels.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on bbc_pkg for field widths.
interface bbc_req_if import bbc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface bbc_rsp_if import bbc_pkg::*;;
   logic                valid;
   logic                ready;
   logic                balanced;
   logic [STATUS_W-1:0] status;
   logic [OPEN_W-1:0]   open_left;

   modport source (output valid, balanced, status, open_left, input ready);
   modport sink   (input valid, balanced, status, open_left, output ready);
endinterface

@@ sv/bbc_front.sv @@
// Front end: accepts request transactions and decodes each byte into a stack command.
// Depends on bbc_pkg and bbc_req_if.
module bbc_front import bbc_pkg::*; (
   bbc_req_if.sink req_ch,
   input  logic    q_full,
   output logic    wr_en,
   output cmd_type wr_cmd
);

   assign req_ch.ready = !q_full;
   assign wr_en        = req_ch.valid && !q_full;
   assign wr_cmd       = classify(req_ch.text_byte, req_ch.end_of_text);

endmodule

@@ sv/bbc_queue.sv @@
// Short command queue between the decoder and the stack engine.
// Depends on bbc_pkg.
module bbc_queue import bbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  cmd_type wr_cmd,
   output logic    full,
   input  logic    rd_en,
   output logic    rd_valid,
   output cmd_type rd_cmd
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

   cmd_type         entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   fill_ff, fill_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      if (p == PW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   assign full     = (fill_ff == NW'(QUEUE_DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rd_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff + NW'(wr_en) - NW'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

@@ sv/bbc_back.sv @@
// Stack engine: executes push/pop commands, tracks the sticky error, drives responses.
// Depends on bbc_pkg, bbc_rsp_if and the assertion macro header.
`include "bracket_balance_checker_defines.svh"
module bbc_back import bbc_pkg::*; #(
   parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_take,
   bbc_rsp_if.source rsp_ch
);

   localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned CWX = (CW > OPEN_W) ? CW : OPEN_W;
   localparam int unsigned OPEN_MAX = (1 << OPEN_W) - 1;

   logic [1:0]          stack_mem [STACK_DEPTH];
   logic [CW-1:0]       count_ff, count_in;
   logic [STATUS_W-1:0] error_ff, error_in;
   kind_type            top_ff, top_in;
   kind_type            below_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                bal_ff, bal_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [OPEN_W-1:0]   open_ff, open_in;
   logic                push_wr;
   logic                end_take;
   logic [CWX-1:0]      count_x;
   logic [CW-1:0]       rd_idx;

   assign q_take   = q_valid && (q_cmd.op != OP_END || !rsp_valid_ff || rsp_ch.ready);
   assign end_take = q_take && q_cmd.op == OP_END;
   assign count_x  = CWX'(count_ff);
   assign rd_idx   = count_in - CW'(2);

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.balanced  = bal_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.open_left = open_ff;

   always_comb begin
      count_in     = count_ff;
      error_in     = error_ff;
      top_in       = top_ff;
      push_wr      = 1'b0;
      bal_in       = bal_ff;
      status_in    = status_ff;
      open_in      = open_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      if (end_take) begin
         if (error_ff != ST_OK) begin
            status_in = error_ff;
         end else if (count_ff != '0) begin
            status_in = ST_LEFT;
         end else begin
            status_in = ST_OK;
         end
         bal_in       = (error_ff == ST_OK) && (count_ff == '0);
         open_in      = (count_x > CWX'(OPEN_MAX)) ? OPEN_W'(OPEN_MAX) : count_x[OPEN_W-1:0];
         rsp_valid_in = 1'b1;
         count_in     = '0;
         error_in     = ST_OK;
      end else if (q_take && error_ff == ST_OK) begin
         unique case (q_cmd.op)
            OP_PUSH: begin
               if (count_ff == CW'(STACK_DEPTH)) begin
                  error_in = ST_OVERFLOW;
               end else begin
                  push_wr  = 1'b1;
                  top_in   = q_cmd.kind;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  error_in = ST_EMPTY;
               end else begin
                  top_in   = below_ff;
                  count_in = count_ff - CW'(1);
                  if (top_ff != q_cmd.kind) begin
                     error_in = ST_MISMATCH;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         error_ff     <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff    <= top_in;
      bal_ff    <= bal_in;
      status_ff <= status_in;
      open_ff   <= open_in;
   end

   // Top lives in top_ff; prefetch the entry under the next top so a pop never waits.
   always_ff @(posedge clock) begin
      if (push_wr) begin
         stack_mem[count_ff[AW-1:0]] <= top_in;
      end
      if (count_in >= CW'(2)) begin
         below_ff <= kind_type'(stack_mem[rd_idx[AW-1:0]]);
      end
   end

   `BBC_ASSERT(a_count_bound, count_ff <= CW'(STACK_DEPTH), "stack count beyond depth")
   `BBC_ASSERT_NEXT(a_error_freeze, q_valid && q_cmd.op != OP_END && error_ff != ST_OK, $stable(count_ff) && $stable(error_ff), "state moved after error")
   `BBC_ASSERT_NEXT(a_end_clears, end_take, rsp_valid_ff && count_ff == '0 && error_ff == ST_OK, "end of text did not clear")
   `BBC_ASSERT(a_bal_status, !rsp_valid_ff || (bal_ff == (status_ff == ST_OK)), "balanced flag disagrees with status")

endmodule

@@ sv/bracket_balance_checker.sv @@
// An accepted end-of-text transaction is registered into the queue, then taken by the stack
// engine once any earlier result has been taken; the engine registers the result and its valid.
// Throughput: one byte per cycle; push and pop on the register-topped stack keep
// this rate, and a stalled response only blocks input once the two-entry queue fills.
// Reset (synchronous): clears stack count, sticky error, queue and response valid.
// The stack memory is not cleared; entries are always written before they are read.
module bracket_balance_checker import bbc_pkg::*; #(
   parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH
) (
   input logic        clock,
   input logic        reset,
   bbc_req_if.sink    req_ch,
   bbc_rsp_if.source  rsp_ch
);

   logic    q_full;
   logic    wr_en;
   cmd_type wr_cmd;
   logic    q_take;
   logic    q_valid;
   cmd_type q_cmd;

   bbc_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .wr_en  (wr_en),
      .wr_cmd (wr_cmd)
   );

   bbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_cmd   (wr_cmd),
      .full     (q_full),
      .rd_en    (q_take),
      .rd_valid (q_valid),
      .rd_cmd   (q_cmd)
   );

   bbc_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_take  (q_take),
      .rsp_ch  (rsp_ch)
   );

endmodule

@@ tb/tb_bracket_balance_checker.sv @@
// Testbench for bracket_balance_checker: a directed table, then random bracket strings.
// Results are checked against a shadow bracket stack kept in the testbench, or against a typed row's verdict.
// Depends on bbc_pkg, bbc_channels.sv and the bracket_balance_checker RTL.
`timescale 1ns / 100ps

module tb_bracket_balance_checker;
   import bbc_pkg::*;

   localparam int unsigned STACK_DEPTH = DEF_STACK_DEPTH;
   localparam int unsigned ITEM_TARGET = 1800;
   localparam int unsigned DRAIN_LIMIT = 20000;

   typedef struct packed {
      logic                balanced;
      logic [STATUS_W-1:0] status;
      logic [OPEN_W-1:0]   open_left;
   } verdict_type;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      logic              eot;
      logic [7:0]        reps;
      logic              typed;
      verdict_type       want;
   } row_type;

   localparam verdict_type NO_CHECK = '{1'b0, ST_OK, 7'd0};
   localparam int NUM_ROWS = 23;

   // Rows with typed set carry their own expected verdict.
   row_type plan [NUM_ROWS] = '{
      '{8'h00,           1'b1, 8'd1,  1'b1, '{1'b1, ST_OK, 7'd0}},
      '{CH_OPEN_ROUND,   1'b0, 8'd1,  1'b0, NO_CHECK},
      '{CH_CLOSE_ROUND,  1'b0, 8'd1,  1'b0, NO_CHECK},
      '{CH_OPEN_SQUARE,  1'b0, 8'd1,  1'b0, NO_CHECK},
      '{CH_CLOSE_SQUARE, 1'b0, 8'd1,  1'b0, NO_CHECK},
      '{CH_OPEN_CURLY,   1'b0, 8'd1,  1'b0, NO_CHECK},
      '{CH_CLOSE_CURLY,  1'b0, 8'd1,  1'b0, NO_CHECK},
      '{8'h00,           1'b0, 8'd1,  1'b0, NO_CHECK},
      '{8'hFF,           1'b0, 8'd1,  1'b0, NO_CHECK},
      '{8'hFF,           1'b1, 8'd1,  1'b1, '{1'b1, ST_OK, 7'd0}},
      '{CH_OPEN_ROUND,   1'b0, 8'd1,  1'b0, NO_CHECK},
      '{CH_CLOSE_SQUARE, 1'b0, 8'd1,  1'b0, NO_CHECK},
      '{CH_OPEN_ROUND,   1'b0, 8'd1,  1'b0, NO_CHECK},
      '{8'h00,           1'b1, 8'd1,  1'b1, '{1'b0, ST_MISMATCH, 7'd0}},
      '{CH_CLOSE_CURLY,  1'b0, 8'd1,  1'b0, NO_CHECK},
      '{CH_OPEN_ROUND,   1'b1, 8'd1,  1'b1, '{1'b0, ST_EMPTY, 7'd0}},
      '{CH_OPEN_SQUARE,  1'b0, 8'd1,  1'b0, NO_CHECK},
      '{8'h00,           1'b1, 8'd1,  1'b1, '{1'b0, ST_LEFT, 7'd1}},
      '{CH_OPEN_CURLY,   1'b0, 8'd64, 1'b0, NO_CHECK},
      '{8'h80,           1'b1, 8'd1,  1'b1, '{1'b0, ST_LEFT, 7'd64}},
      '{CH_OPEN_ROUND,   1'b0, 8'd65, 1'b0, NO_CHECK},
      '{CH_CLOSE_ROUND,  1'b0, 8'd1,  1'b0, NO_CHECK},
      '{8'h7F,           1'b1, 8'd1,  1'b1, '{1'b0, ST_OVERFLOW, 7'd64}}
   };

   logic clock;
   logic reset;

   bbc_req_if req_ch ();
   bbc_rsp_if rsp_ch ();

   bracket_balance_checker #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the bracket stack
   kind_type          shadow_stack [STACK_DEPTH];
   int unsigned       shadow_depth = 0;
   logic [STATUS_W-1:0] shadow_err = ST_OK;

   verdict_type pending_verdicts [$];
   verdict_type want_v;
   int unsigned sent_items = 0;
   int unsigned mismatch_count = 0;
   int unsigned gap_pct = 8;
   int unsigned stall_pct = 76;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic void decode_char(input logic [BYTE_W-1:0] ch, output logic opens,
                                       output logic closes, output kind_type k);
      opens  = 1'b0;
      closes = 1'b0;
      k      = KIND_ROUND;
      unique case (ch)
         CH_OPEN_ROUND:   opens = 1'b1;
         CH_OPEN_SQUARE: begin
            opens = 1'b1;
            k     = KIND_SQUARE;
         end
         CH_OPEN_CURLY: begin
            opens = 1'b1;
            k     = KIND_CURLY;
         end
         CH_CLOSE_ROUND:  closes = 1'b1;
         CH_CLOSE_SQUARE: begin
            closes = 1'b1;
            k      = KIND_SQUARE;
         end
         CH_CLOSE_CURLY: begin
            closes = 1'b1;
            k      = KIND_CURLY;
         end
         default: ;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] opener_of(input kind_type k);
      unique case (k)
         KIND_SQUARE: return CH_OPEN_SQUARE;
         KIND_CURLY:  return CH_OPEN_CURLY;
         default:     return CH_OPEN_ROUND;
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] closer_of(input kind_type k);
      unique case (k)
         KIND_SQUARE: return CH_CLOSE_SQUARE;
         KIND_CURLY:  return CH_CLOSE_CURLY;
         default:     return CH_CLOSE_ROUND;
      endcase
   endfunction

   function automatic kind_type random_kind();
      return kind_type'($urandom_range(2));
   endfunction

   function automatic logic [BYTE_W-1:0] filler_byte();
      logic [BYTE_W-1:0] ch;
      logic              opens;
      logic              closes;
      kind_type          k;
      do begin
         ch = BYTE_W'($urandom_range(255));
         decode_char(ch, opens, closes, k);
      end while (opens || closes);
      return ch;
   endfunction

   // Apply one accepted transaction to the shadow stack; returns 1 when a verdict is due.
   function automatic logic track_brackets(input logic [BYTE_W-1:0] ch, input logic eot,
                                           output verdict_type v);
      logic     opens;
      logic     closes;
      kind_type k;
      v = NO_CHECK;
      if (eot) begin
         v.status = shadow_err;
         if (shadow_err == ST_OK && shadow_depth != 0)
            v.status = ST_LEFT;
         v.balanced  = (v.status == ST_OK);
         v.open_left = (shadow_depth > 127) ? 7'd127 : OPEN_W'(shadow_depth);
         shadow_depth = 0;
         shadow_err   = ST_OK;
         return 1'b1;
      end
      // a sticky error freezes the stack until end of text
      if (shadow_err != ST_OK)
         return 1'b0;
      decode_char(ch, opens, closes, k);
      if (opens) begin
         if (shadow_depth >= STACK_DEPTH) begin
            shadow_err = ST_OVERFLOW;
         end else begin
            shadow_stack[shadow_depth] = k;
            shadow_depth++;
         end
      end else if (closes) begin
         if (shadow_depth == 0) begin
            shadow_err = ST_EMPTY;
         end else begin
            shadow_depth--;
            if (shadow_stack[shadow_depth] != k)
               shadow_err = ST_MISMATCH;
         end
      end
      return 1'b0;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic put_char(input logic [BYTE_W-1:0] ch, input logic eot, input logic typed,
                           input verdict_type want);
      verdict_type guess;
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.text_byte   <= ch;
      req_ch.end_of_text <= eot;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
      if (track_brackets(ch, eot, guess))
         pending_verdicts.push_back(typed ? want : guess);
      @(negedge clock);
   endtask

   task automatic send_text();
      logic [BYTE_W-1:0] text_q [$];
      kind_type          open_q [$];
      kind_type          k;
      int                style;
      int                len;
      int                pick;
      int                n;
      style = $urandom_range(99);
      len   = ($urandom_range(9) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 16);
      if (style < 70) begin
         // well-formed nesting with filler bytes
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(9);
            if (pick < 4 && open_q.size() < STACK_DEPTH) begin
               k = random_kind();
               open_q.push_back(k);
               text_q.push_back(opener_of(k));
            end else if (pick < 7 && open_q.size() != 0) begin
               text_q.push_back(closer_of(open_q.pop_back()));
            end else begin
               text_q.push_back(filler_byte());
            end
         end
         while (open_q.size() != 0)
            text_q.push_back(closer_of(open_q.pop_back()));
         // break some of them
         if (style >= 55) begin
            pick = $urandom_range(3);
            case (pick)
               0: begin
                  if (text_q.size() != 0) begin
                     n = $urandom_range(text_q.size() - 1);
                     text_q[n] = closer_of(random_kind());
                  end else begin
                     text_q.push_back(closer_of(random_kind()));
                  end
               end
               1: text_q.push_front(closer_of(random_kind()));
               2: text_q.push_front(opener_of(random_kind()));
               default: text_q.push_back(closer_of(random_kind()));
            endcase
         end
      end else if (style < 78) begin
         // deep nesting around the stack capacity
         n = $urandom_range(STACK_DEPTH - 6, STACK_DEPTH + 4);
         repeat (n) begin
            k = random_kind();
            open_q.push_back(k);
            text_q.push_back(opener_of(k));
         end
         n = $urandom_range(1) ? open_q.size() : $urandom_range(open_q.size());
         repeat (n)
            text_q.push_back(closer_of(open_q.pop_back()));
      end else if (style < 88) begin
         repeat (len) begin
            k = random_kind();
            text_q.push_back($urandom_range(1) ? opener_of(k) : closer_of(k));
         end
      end else begin
         repeat (len)
            text_q.push_back(BYTE_W'($urandom_range(255)));
      end
      foreach (text_q[i])
         put_char(text_q[i], 1'b0, 1'b0, NO_CHECK);
      put_char(BYTE_W'($urandom_range(255)), 1'b1, 1'b0, NO_CHECK);
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with no transaction pending: balanced %0d status %0d open_left %0d",
                   rsp_ch.balanced, rsp_ch.status, rsp_ch.open_left);
            mismatch_count++;
         end else begin
            want_v = pending_verdicts.pop_front();
            if (rsp_ch.balanced !== want_v.balanced) begin
               $error("balanced: expected %0d, got %0d", want_v.balanced, rsp_ch.balanced);
               mismatch_count++;
            end
            if (rsp_ch.status !== want_v.status) begin
               $error("status: expected %0d, got %0d", want_v.status, rsp_ch.status);
               mismatch_count++;
            end
            if (rsp_ch.open_left !== want_v.open_left) begin
               $error("open_left: expected %0d, got %0d", want_v.open_left, rsp_ch.open_left);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int unsigned waited;
      req_ch.valid       = 1'b0;
      req_ch.text_byte   = '0;
      req_ch.end_of_text = 1'b0;
      rsp_ch.ready       = 1'b0;
      reset              = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r])
         repeat (plan[r].reps)
            put_char(plan[r].ch, plan[r].eot, plan[r].typed, plan[r].want);

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct   = (phase == 0) ? 8 : (phase == 1) ? 76 : 0;
         stall_pct = (phase == 0) ? 76 : (phase == 1) ? 8 : 0;
         while (sent_items < (phase + 1) * ITEM_TARGET / 3)
            send_text();
      end
      req_ch.valid <= 1'b0;

      // drain outstanding results, then allow for the pipeline latency
      waited = 0;
      while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d results never arrived", pending_verdicts.size());
         mismatch_count++;
      end

      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
